### rtl/tms_pkg.sv
// Shared types and constants of the tape machine rule stepper.
// No dependencies; imported by every module of the block.
package tms_pkg;

  // Action codes of an input transfer
  localparam logic [1:0] ACT_LOAD_RULE = 2'd0;
  localparam logic [1:0] ACT_LOAD_TAPE = 2'd1;
  localparam logic [1:0] ACT_START     = 2'd2;
  localparam logic [1:0] ACT_STEP      = 2'd3;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_RULE_COUNT  = 2'd0;
  localparam logic [1:0] REG_TAPE_LENGTH = 2'd1;
  localparam logic [1:0] REG_START_STATE = 2'd2;
  localparam logic [1:0] REG_START_HEAD  = 2'd3;

  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam int RC_W  = 7;
  localparam int TL_W  = 11;
  localparam int SYM_W = 8;
  localparam int ST_W  = 8;
  localparam int POS_W = 10;
  localparam int CNT_W = 32;

  typedef struct packed {
    logic [1:0]       action;
    logic [5:0]       rule_index;
    logic [ST_W-1:0]  rule_state;
    logic [SYM_W-1:0] rule_read_symbol;
    logic [SYM_W-1:0] rule_write_symbol;
    logic             rule_move_right;
    logic [ST_W-1:0]  rule_next_state;
    logic [POS_W-1:0] cell_position;
    logic [SYM_W-1:0] cell_symbol;
  } in_item_t;

  typedef struct packed {
    logic             matched;
    logic [ST_W-1:0]  machine_state;
    logic [POS_W-1:0] head_now;
    logic [SYM_W-1:0] written_symbol;
    logic [CNT_W-1:0] steps_taken;
  } out_item_t;

  // One rule table entry (33 bits)
  typedef struct packed {
    logic [ST_W-1:0]  state;
    logic [SYM_W-1:0] read_sym;
    logic [SYM_W-1:0] write_sym;
    logic             move_right;
    logic [ST_W-1:0]  goto_state;
  } rule_t;

  // Priority chain passed from cell to cell: first hit wins
  typedef struct packed {
    logic  found;
    rule_t rule;
  } chain_t;

endpackage

### rtl/tms_rule_cell.sv
// One rule cell: holds a rule entry, compares it against the current key
// and joins the first-hit priority chain. Depends on tms_pkg.
module tms_rule_cell (
  input  logic                  clk,
  input  logic                  we,
  input  tms_pkg::rule_t        wdata,
  input  logic                  en,
  input  logic [7:0]            key_state,
  input  logic [7:0]            key_sym,
  input  tms_pkg::chain_t       chain_in,
  output tms_pkg::chain_t       chain_out
);
  import tms_pkg::*;

  rule_t entry_r;
  logic  hit;
  logic  win;

  always_ff @(posedge clk) begin
    if (we) begin
      entry_r <= wdata;
    end
  end

  assign hit = en && (entry_r.state == key_state) && (entry_r.read_sym == key_sym);
  assign win = hit && !chain_in.found;

  assign chain_out.found = chain_in.found | hit;
  assign chain_out.rule  = rule_t'(chain_in.rule | (entry_r & {$bits(rule_t){win}}));

endmodule

### rtl/tms_tape_ram.sv
// Tape store: single write port, one registered read port.
// Depends on tms_pkg for the symbol width.
module tms_tape_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [tms_pkg::SYM_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [tms_pkg::SYM_W-1:0] rdata
);
  import tms_pkg::*;

  logic [SYM_W-1:0] mem [DEPTH];
  logic [SYM_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/tape_machine_rule_stepper_core.sv
// Top level of the tape machine rule stepper: command port, APB config,
// rule cell row and tape store. Depends on tms_pkg, tms_rule_cell, tms_tape_ram.
//
//  channel   direction  handshake            payload
//  ------------------------------------------------------------------
//  input     in         start & !busy        in_item  (tms_pkg::in_item_t)
//  result    out        out_valid, 1 cycle   out_item (tms_pkg::out_item_t)
//  config    in/out     psel&penable&pwrite  pwdata/prdata at paddr[3:2]
//
//  Load rule, load tape and start leave busy low; the result strobes on
//  the cycle after the transfer.
//  A step first registers the tape read in the RAM, then the rule row
//  matches, the tape is written and state/head/count update.
//  busy is high while the rule row matches; the result strobes after it.
//  rst_n is synchronous; rule table and tape are not cleared and no
//  clearing pass runs. The receiver cannot stall: out_valid lasts one cycle.
module tape_machine_rule_stepper_core #(
  parameter int RULE_DEPTH = 64,
  parameter int TAPE_DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  tms_pkg::in_item_t            in_item,
  // result channel
  output logic                         out_valid,
  output tms_pkg::out_item_t           out_item,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tms_pkg::CFG_AW-1:0]   paddr,
  input  logic [tms_pkg::CFG_DW-1:0]   pwdata,
  output logic [tms_pkg::CFG_DW-1:0]   prdata,
  output logic                         pready
);
  import tms_pkg::*;

  // Head width, width that holds the length itself, and compare width
  localparam int HEAD_W = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
  localparam int LEN_W  = $clog2(TAPE_DEPTH + 1);
  localparam int CMP_W  = (LEN_W > TL_W) ? LEN_W : TL_W;

  typedef enum logic {S_IDLE, S_STEP} fsm_t;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [RC_W-1:0]  rule_count_r;
  logic [TL_W-1:0]  tape_length_r;
  logic [ST_W-1:0]  start_state_r;
  logic [POS_W-1:0] start_head_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_count_r  <= '0;
      tape_length_r <= TL_W'(1);
      start_state_r <= '0;
      start_head_r  <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_RULE_COUNT:  rule_count_r  <= pwdata[RC_W-1:0];
        REG_TAPE_LENGTH: tape_length_r <= pwdata[TL_W-1:0];
        REG_START_STATE: start_state_r <= pwdata[ST_W-1:0];
        REG_START_HEAD:  start_head_r  <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RULE_COUNT:  prdata = CFG_DW'(rule_count_r);
      REG_TAPE_LENGTH: prdata = CFG_DW'(tape_length_r);
      REG_START_STATE: prdata = CFG_DW'(start_state_r);
      REG_START_HEAD:  prdata = CFG_DW'(start_head_r);
      default:         prdata = '0;
    endcase
  end

  // Effective tape length: zero acts as one, capped at the store depth
  logic [CMP_W-1:0] len_eff;
  always_comb begin
    if (tape_length_r == '0) begin
      len_eff = CMP_W'(1);
    end else if (CMP_W'(tape_length_r) > CMP_W'(TAPE_DEPTH)) begin
      len_eff = CMP_W'(TAPE_DEPTH);
    end else begin
      len_eff = CMP_W'(tape_length_r);
    end
  end

  // ---------------------------------------------------------------------
  // Machine state
  // ---------------------------------------------------------------------
  fsm_t             state_r, state_nxt;
  logic [ST_W-1:0]  mstate_r, mstate_nxt;
  logic [HEAD_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] steps_r, steps_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic in_xfer;
  assign busy    = (state_r == S_STEP);
  assign in_xfer = start && !busy;

  // ---------------------------------------------------------------------
  // Rule cell row: each cell matches in parallel, first hit ripples down
  // ---------------------------------------------------------------------
  logic [SYM_W-1:0] tape_rdata;
  chain_t           chain [RULE_DEPTH+1];
  rule_t            new_rule;

  assign chain[0] = '0;
  assign new_rule = '{state:      in_item.rule_state,
                      read_sym:   in_item.rule_read_symbol,
                      write_sym:  in_item.rule_write_symbol,
                      move_right: in_item.rule_move_right,
                      goto_state: in_item.rule_next_state};

  for (genvar i = 0; i < RULE_DEPTH; i++) begin : g_cell
    logic cell_we;
    logic cell_en;
    assign cell_we = in_xfer && (in_item.action == ACT_LOAD_RULE) &&
                     (32'(in_item.rule_index) == i);
    // rule_count beyond the row depth just enables the whole row
    assign cell_en = (32'(rule_count_r) > i);

    tms_rule_cell u_cell (
      .clk       (clk),
      .we        (cell_we),
      .wdata     (new_rule),
      .en        (cell_en),
      .key_state (mstate_r),
      .key_sym   (tape_rdata),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1])
    );
  end

  logic  found;
  rule_t win_rule;
  assign found    = chain[RULE_DEPTH].found;
  assign win_rule = chain[RULE_DEPTH].rule;

  // ---------------------------------------------------------------------
  // Tape store: loads write on transfer, a firing step writes back
  // ---------------------------------------------------------------------
  logic              tape_we, tape_re;
  logic [HEAD_W-1:0] tape_waddr;
  logic [SYM_W-1:0]  tape_wdata;
  logic              load_tape_ok;

  assign load_tape_ok = in_xfer && (in_item.action == ACT_LOAD_TAPE) &&
                        (32'(in_item.cell_position) < TAPE_DEPTH);
  assign tape_re = in_xfer && (in_item.action == ACT_STEP);

  always_comb begin
    if (busy) begin
      tape_we    = found;
      tape_waddr = head_r;
      tape_wdata = win_rule.write_sym;
    end else begin
      tape_we    = load_tape_ok;
      tape_waddr = HEAD_W'(in_item.cell_position);
      tape_wdata = in_item.cell_symbol;
    end
  end

  tms_tape_ram #(
    .DEPTH (TAPE_DEPTH),
    .AW    (HEAD_W)
  ) u_tape (
    .clk   (clk),
    .we    (tape_we),
    .waddr (tape_waddr),
    .wdata (tape_wdata),
    .re    (tape_re),
    .raddr (head_r),
    .rdata (tape_rdata)
  );

  // ---------------------------------------------------------------------
  // Head move with wrap; a head beyond a shrunk tape wraps right to zero
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0]  head_inc;
  logic [HEAD_W-1:0] head_moved;
  logic [HEAD_W-1:0] head_start;

  assign head_inc = CMP_W'(head_r) + CMP_W'(1);

  always_comb begin
    if (win_rule.move_right) begin
      head_moved = (head_inc >= len_eff) ? '0 : HEAD_W'(head_inc);
    end else begin
      head_moved = (head_r == '0) ? HEAD_W'(len_eff - CMP_W'(1)) : head_r - HEAD_W'(1);
    end
  end

  assign head_start = (CMP_W'(start_head_r) < len_eff) ? HEAD_W'(start_head_r) : '0;

  // ---------------------------------------------------------------------
  // Next-state logic
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    mstate_nxt    = mstate_r;
    head_nxt      = head_r;
    steps_nxt     = steps_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_item.action)
            ACT_STEP: begin
              state_nxt = S_STEP;
            end
            ACT_START: begin
              mstate_nxt    = start_state_r;
              head_nxt      = head_start;
              steps_nxt     = '0;
              out_valid_nxt = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_STEP: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        if (found) begin
          mstate_nxt = win_rule.goto_state;
          head_nxt   = head_moved;
          if (steps_r != '1) begin
            steps_nxt = steps_r + CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_nxt.matched        = busy ? found : 1'b1;
    out_nxt.machine_state  = mstate_nxt;
    out_nxt.head_now       = POS_W'(head_nxt);
    out_nxt.written_symbol = (busy && found) ? win_rule.write_sym : '0;
    out_nxt.steps_taken    = steps_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mstate_r    <= '0;
      head_r      <= '0;
      steps_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mstate_r    <= mstate_nxt;
      head_r      <= head_nxt;
      steps_r     <= steps_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_busy_follows_step : assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> $past(in_xfer) && ($past(in_item.action) == ACT_STEP))
    else $error("busy without a preceding step transfer");

  a_short_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_item.action != ACT_STEP) |=> out_valid && !busy)
    else $error("load/start transfer gave no result on the next cycle");

  a_step_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_item.action == ACT_STEP) |-> ##2 out_valid)
    else $error("step transfer gave no result two cycles later");

  a_halt_writes_nothing : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.matched |-> (out_item.written_symbol == '0) &&
      $stable(head_r) && $stable(mstate_r))
    else $error("halted step changed machine state or head");

endmodule

### sim/tms_result_checker.sv
// Result checker for the tape machine rule stepper: watches the command, result
// and config ports, predicts each result and compares it. Depends on tms_pkg.
module tms_result_checker #(
  parameter int RULE_DEPTH = 64,
  parameter int TAPE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  tms_pkg::in_item_t          in_item,
  input  logic                       out_valid,
  input  tms_pkg::out_item_t         out_item,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [tms_pkg::CFG_AW-1:0] paddr,
  input  logic [tms_pkg::CFG_DW-1:0] pwdata,
  output int                         error_count,
  output int                         pending,
  output int                         n_results,
  output int                         n_fired,
  output int                         n_halted
);
  timeunit 1ns;
  timeprecision 1ps;
  import tms_pkg::*;

  // Machine copy
  rule_t            rule_mem [RULE_DEPTH];
  logic [SYM_W-1:0] tape_mem [TAPE_DEPTH];
  logic [ST_W-1:0]  cur_state;
  logic [POS_W-1:0] head;
  logic [CNT_W-1:0] step_cnt;

  // Register copy
  logic [RC_W-1:0]  rule_count_r;
  logic [TL_W-1:0]  tape_length_r;
  logic [ST_W-1:0]  start_state_r;
  logic [POS_W-1:0] start_head_r;

  out_item_t awaited_results [$];
  out_item_t want;

  task automatic report(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    error_count++;
  endtask

  function automatic int tape_len_eff();
    int len;
    len = tape_length_r;
    if (len == 0) len = 1;
    if (len > TAPE_DEPTH) len = TAPE_DEPTH;
    return len;
  endfunction

  // Applies one transfer to the machine copy and returns the result it causes.
  function automatic out_item_t advance_machine(input in_item_t it);
    out_item_t res;
    int        len;
    int        lim;
    int        h;
    int        i;
    logic      hit;
    rule_t     r;
    res = '0;
    res.matched = 1'b1;
    case (it.action)
      ACT_LOAD_RULE: begin
        r.state      = it.rule_state;
        r.read_sym   = it.rule_read_symbol;
        r.write_sym  = it.rule_write_symbol;
        r.move_right = it.rule_move_right;
        r.goto_state = it.rule_next_state;
        rule_mem[it.rule_index] = r;
      end
      ACT_LOAD_TAPE: tape_mem[it.cell_position] = it.cell_symbol;
      ACT_START: begin
        cur_state = start_state_r;
        head      = (int'(start_head_r) < tape_len_eff()) ? start_head_r : '0;
        step_cnt  = '0;
      end
      default: begin
        len = tape_len_eff();
        lim = (rule_count_r > RULE_DEPTH) ? RULE_DEPTH : rule_count_r;
        hit = 1'b0;
        for (i = 0; i < lim && !hit; i++) begin
          r = rule_mem[i];
          if (r.state == cur_state && r.read_sym == tape_mem[head]) begin
            hit = 1'b1;
            tape_mem[head] = r.write_sym;
            res.written_symbol = r.write_sym;
            h = head;
            if (r.move_right) h = (h + 1 >= len) ? 0 : h + 1;
            else              h = (h == 0) ? len - 1 : h - 1;
            head = h[POS_W-1:0];
            cur_state = r.goto_state;
            if (step_cnt != '1) step_cnt++;
          end
        end
        res.matched = hit;
        if (hit) n_fired++;
        else     n_halted++;
      end
    endcase
    res.machine_state = cur_state;
    res.head_now      = head;
    res.steps_taken   = step_cnt;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_state     = '0;
      head          = '0;
      step_cnt      = '0;
      rule_count_r  = '0;
      tape_length_r = TL_W'(1);
      start_state_r = '0;
      start_head_r  = '0;
      awaited_results.delete();
      error_count = 0;
      n_results   = 0;
      n_fired     = 0;
      n_halted    = 0;
    end else begin
      // result first: it never belongs to a transfer taken at this same edge
      if (out_valid) begin
        n_results++;
        if (awaited_results.size() == 0) begin
          report($sformatf("result with nothing awaited: %h", out_item));
        end else begin
          want = awaited_results.pop_front();
          if (out_item.matched !== want.matched)
            report($sformatf("matched: got %b, expected %b",
                             out_item.matched, want.matched));
          if (out_item.machine_state !== want.machine_state)
            report($sformatf("machine_state: got %h, expected %h",
                             out_item.machine_state, want.machine_state));
          if (out_item.head_now !== want.head_now)
            report($sformatf("head_now: got %0d, expected %0d",
                             out_item.head_now, want.head_now));
          if (out_item.written_symbol !== want.written_symbol)
            report($sformatf("written_symbol: got %h, expected %h",
                             out_item.written_symbol, want.written_symbol));
          if (out_item.steps_taken !== want.steps_taken)
            report($sformatf("steps_taken: got %0d, expected %0d",
                             out_item.steps_taken, want.steps_taken));
        end
      end
      if (start && !busy) awaited_results.push_back(advance_machine(in_item));
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_RULE_COUNT:  rule_count_r  = pwdata[RC_W-1:0];
          REG_TAPE_LENGTH: tape_length_r = pwdata[TL_W-1:0];
          REG_START_STATE: start_state_r = pwdata[ST_W-1:0];
          REG_START_HEAD:  start_head_r  = pwdata[POS_W-1:0];
          default: ;
        endcase
      end
    end
    pending <= awaited_results.size();
  end

endmodule

### sim/tape_machine_rule_stepper_core_test.sv
// Top of the tape machine rule stepper testbench: clock, reset, stimulus and verdict.
// Depends on tms_pkg, tape_machine_rule_stepper_core and tms_result_checker.
module tape_machine_rule_stepper_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tms_pkg::*;

  localparam int ITEM_TARGET = 1250;   // random stimulus stops past this many transfers
  localparam int QUIET_FROM  = 1050;   // no idling from here to the end
  localparam int CYCLE_LIMIT = 500000; // worst case is far below this

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_item;
  logic              out_valid;
  out_item_t         out_item;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  int error_count;
  int pending;
  int n_results;
  int n_fired;
  int n_halted;

  int items_sent;
  int phases_run;
  int cycle_count = 0;
  bit idle_ok;       // cleared for stretches of back-to-back transfers

  tape_machine_rule_stepper_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tms_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .error_count(error_count),
    .pending    (pending),
    .n_results  (n_results),
    .n_fired    (n_fired),
    .n_halted   (n_halted)
  );

  always #5 clk = ~clk;

  // Watchdog: a lost result or a stuck busy ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_count, pending);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Byte with the extremes weighted in.
  function automatic logic [7:0] any_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Every field random; the action decides which fields matter.
  function automatic in_item_t rand_item();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t mk_ctrl(input logic [1:0] act);
    in_item_t it;
    it = rand_item();
    it.action = act;
    return it;
  endfunction

  function automatic in_item_t mk_rule(input int idx, input logic [7:0] st,
                                       input logic [7:0] rd, input logic [7:0] wr,
                                       input logic mv, input logic [7:0] nx);
    in_item_t it;
    it = mk_ctrl(ACT_LOAD_RULE);
    it.rule_index        = 6'(idx);
    it.rule_state        = st;
    it.rule_read_symbol  = rd;
    it.rule_write_symbol = wr;
    it.rule_move_right   = mv;
    it.rule_next_state   = nx;
    return it;
  endfunction

  function automatic in_item_t mk_cell(input int pos, input logic [7:0] sym);
    in_item_t it;
    it = mk_ctrl(ACT_LOAD_TAPE);
    it.cell_position = POS_W'(pos);
    it.cell_symbol   = sym;
    return it;
  endfunction

  // One command transfer. start is left high afterwards so the next transfer
  // can follow without a gap; an idle burst, when drawn, comes first.
  task automatic send_item(input in_item_t it);
    if (idle_ok && items_sent < QUIET_FROM && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // Stop issuing and let every awaited result come back. A step is busy while
  // its rule row matches, so a short margin covers the block's latency.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup, access (register written at its closing edge), then
  // idle. Bits above the register's width carry random junk.
  task automatic cfg_write(input logic [1:0] idx, input int unsigned val);
    int unsigned mask;
    case (idx)
      REG_RULE_COUNT:  mask = (1 << RC_W) - 1;
      REG_TAPE_LENGTH: mask = (1 << TL_W) - 1;
      REG_START_STATE: mask = (1 << ST_W) - 1;
      default:         mask = (1 << POS_W) - 1;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= (val & mask) | ($urandom & ~mask);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_directed();
    // Reset registers: no rules, one-cell tape, so a step can only halt.
    send_item(mk_cell(0, 8'hA5));
    send_item(mk_ctrl(ACT_START));
    send_item(mk_ctrl(ACT_STEP));
    drain();

    // Tape length 0 behaves as one cell; a start head past the tape snaps to 0.
    // Moves both ways wrap onto the single cell. Rule 63 stays outside the count.
    cfg_write(REG_RULE_COUNT, 2);
    cfg_write(REG_TAPE_LENGTH, 0);
    cfg_write(REG_START_STATE, 8'hFF);
    cfg_write(REG_START_HEAD, 10'h3FF);
    send_item(mk_rule(0, 8'hFF, 8'hA5, 8'h00, 1'b1, 8'h00));
    send_item(mk_rule(1, 8'h00, 8'h00, 8'hFF, 1'b0, 8'hFF));
    send_item(mk_rule(63, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF));
    send_item(mk_ctrl(ACT_START));
    repeat (3) send_item(mk_ctrl(ACT_STEP));   // fire, fire, halt
    drain();

    // Length above the tape size acts as the full tape: wrap at cell 1023.
    cfg_write(REG_TAPE_LENGTH, 2047);
    cfg_write(REG_START_STATE, 8'h00);
    cfg_write(REG_START_HEAD, 1023);
    send_item(mk_cell(1023, 8'h5A));
    send_item(mk_cell(1022, 8'h3C));
    send_item(mk_cell(0, 8'h81));
    send_item(mk_rule(0, 8'h00, 8'h5A, 8'h3C, 1'b1, 8'h01));
    send_item(mk_rule(1, 8'h01, 8'h81, 8'h7E, 1'b0, 8'h00));
    send_item(mk_ctrl(ACT_START));
    repeat (3) send_item(mk_ctrl(ACT_STEP));   // right wrap, left wrap, halt
    drain();

    // Shrink the tape under a head sitting at 1023, no restart: a left move
    // steps down by one, a right move from beyond the end wraps to 0.
    cfg_write(REG_TAPE_LENGTH, 4);
    send_item(mk_rule(0, 8'h00, 8'h3C, 8'hC3, 1'b0, 8'h01));
    send_item(mk_rule(1, 8'h01, 8'h3C, 8'h11, 1'b1, 8'h02));
    repeat (3) send_item(mk_ctrl(ACT_STEP));
    drain();
  endtask

  // One random program: settings, rules over a small alphabet, the tape cells
  // the head can reach, a start, then steps with some noise mixed in.
  task automatic run_phase();
    logic [7:0]  syms [4];
    logic [7:0]  states [4];
    int          nsym;
    int          nst;
    int unsigned rc;
    int unsigned tl;
    int unsigned ss;
    int unsigned sh;
    int          leff;
    int          h0;
    int          nrules;
    int          nsteps;
    int          radius;
    int          i;
    int          d;
    in_item_t    it;

    idle_ok = ($urandom_range(0, 3) != 0);
    nsym = $urandom_range(1, 4);
    nst  = $urandom_range(1, 4);
    for (i = 0; i < 4; i++) begin
      syms[i]   = any_byte();
      states[i] = any_byte();
    end

    case ($urandom_range(0, 19))
      0, 1:    rc = 0;
      2, 3:    rc = $urandom_range(65, 127);   // capped at the table depth
      4:       rc = 64;
      default: rc = $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 9))
      0:       tl = 0;
      1:       tl = 1;
      2:       tl = $urandom_range(1025, 2047);
      3:       tl = 1024;
      4:       tl = $urandom_range(17, 1023);
      default: tl = $urandom_range(2, 16);
    endcase
    leff = (tl == 0) ? 1 : (tl > 1024) ? 1024 : tl;
    ss = ($urandom_range(0, 7) == 0) ? any_byte() : states[$urandom_range(0, nst - 1)];
    case ($urandom_range(0, 7))
      0:       sh = 1023;
      1:       sh = 0;
      2, 3:    sh = $urandom_range(0, 1023);
      default: sh = $urandom_range(0, leff - 1);
    endcase
    h0 = (sh < leff) ? sh : 0;

    cfg_write(REG_RULE_COUNT, rc);
    cfg_write(REG_TAPE_LENGTH, tl);
    cfg_write(REG_START_STATE, ss);
    cfg_write(REG_START_HEAD, sh);

    // Every rule inside the count is rewritten, so none is ever unset.
    nrules = (rc > 64) ? 64 : rc;
    for (i = 0; i < nrules; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        it = mk_ctrl(ACT_LOAD_RULE);
        it.rule_index = 6'(i);
      end else begin
        it = mk_rule(i, states[$urandom_range(0, nst - 1)], syms[$urandom_range(0, nsym - 1)],
                     syms[$urandom_range(0, nsym - 1)], 1'($urandom),
                     states[$urandom_range(0, nst - 1)]);
      end
      send_item(it);
    end

    // Steps plus noise steps never exceed 2*nsteps, so the head stays inside
    // this window around its start position.
    nsteps = $urandom_range(4, 16);
    radius = 2 * nsteps;
    if (2 * radius + 1 >= leff) begin
      for (i = 0; i < leff; i++)
        send_item(mk_cell(i, ($urandom_range(0, 15) == 0) ? any_byte()
                                                         : syms[$urandom_range(0, nsym - 1)]));
    end else begin
      for (d = -radius; d <= radius; d++)
        send_item(mk_cell(((h0 + d) % leff + leff) % leff,
                          ($urandom_range(0, 15) == 0) ? any_byte()
                                                       : syms[$urandom_range(0, nsym - 1)]));
    end

    send_item(mk_ctrl(ACT_START));
    for (i = 0; i < nsteps; i++) begin
      if ($urandom_range(0, 7) == 0) send_item(rand_item());
      send_item(mk_ctrl(ACT_STEP));
    end
    phases_run++;
  endtask

  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    items_sent  = 0;
    phases_run  = 0;
    idle_ok     = 1'b1;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    while (items_sent < ITEM_TARGET) begin
      run_phase();
      drain();
    end
    repeat (5) @(posedge clk);

    $display("Sent %0d transfers (%0d random programs), checked %0d results.",
             items_sent, phases_run, n_results);
    $display("Steps that fired a rule: %0d, steps that halted: %0d.", n_fired, n_halted);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/tms_pkg.sv
rtl/tms_rule_cell.sv
rtl/tms_tape_ram.sv
rtl/tape_machine_rule_stepper_core.sv
sim/tms_result_checker.sv
sim/tape_machine_rule_stepper_core_test.sv
